// ===== src/pst_pkg.sv =====
`default_nettype none
package pst_pkg;

    localparam int MAX_LEXEME_DEF    = 32;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int KEYWORD_LEN       = 7;

    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_PROGRAM = 5'd1;
    localparam logic [4:0] KIND_NUMBER  = 5'd2;
    localparam logic [4:0] KIND_PLUS    = 5'd3;
    localparam logic [4:0] KIND_DOT     = 5'd10;
    localparam logic [4:0] KIND_ERROR   = 5'd16;
    localparam logic [4:0] KIND_END     = 5'd17;

    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_IDENT  = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_OPER   = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [4:0]  len;
        logic        trunc;
    } token_t;

    // one or two tokens caused by one input item
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } pair_t;

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "p";
            3'd1:    c = "r";
            3'd2:    c = "o";
            3'd3:    c = "g";
            3'd4:    c = "r";
            3'd5:    c = "a";
            3'd6:    c = "m";
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    // {found, code} in order + - * / = < >
    function automatic logic [3:0] oper_lookup(input logic [7:0] b);
        logic [3:0] r;
        unique case (b)
            "+":     r = 4'b1000;
            "-":     r = 4'b1001;
            "*":     r = 4'b1010;
            "/":     r = 4'b1011;
            "=":     r = 4'b1100;
            "<":     r = 4'b1101;
            ">":     r = 4'b1110;
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

    // {found, code} in order . ; , : ( )
    function automatic logic [3:0] punct_lookup(input logic [7:0] b);
        logic [3:0] r;
        unique case (b)
            ".":     r = 4'b1000;
            ";":     r = 4'b1001;
            ",":     r = 4'b1010;
            ":":     r = 4'b1011;
            "(":     r = 4'b1100;
            ")":     r = 4'b1101;
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/pst_front.sv =====
`default_nettype none
module pst_front #(
    parameter int MAX_LEXEME    = pst_pkg::MAX_LEXEME_DEF,
    parameter int POSITION_BITS = pst_pkg::POSITION_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     text_byte,
    output logic                tok_push,
    output pst_pkg::pair_t      tok_pair
);

    localparam int RLW = $clog2(MAX_LEXEME + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    pst_pkg::mode_t           mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [RLW-1:0]           rl_reg, rl_next;
    logic [2:0]               kp_reg, kp_next;
    logic                     ka_reg, ka_next;
    logic [2:0]               of_reg, of_next;

    logic        is_letter, is_digit, is_space, extend;
    logic        op_found, pu_found;
    logic [2:0]  op_code, pu_code;
    logic        has_pending, new_valid;
    logic        kw_hit;
    logic        len_sat;
    logic [31:0] pos_ext, start_ext, len_ext;
    pst_pkg::token_t pend_tok, new_tok;

    assign pos_ext   = 32'(pos_reg);
    assign start_ext = 32'(start_reg);

    always_comb
    begin
        is_letter = (text_byte >= "A" && text_byte <= "Z") ||
                    (text_byte >= "a" && text_byte <= "z") ||
                    text_byte == pst_pkg::CHAR_UNDERSCORE;
        is_digit  = text_byte >= "0" && text_byte <= "9";
        is_space  = text_byte == " " || (text_byte >= 8'd9 && text_byte <= 8'd13);
        {op_found, op_code} = pst_pkg::oper_lookup(text_byte);
        {pu_found, pu_code} = pst_pkg::punct_lookup(text_byte);

        unique case (mode_reg)
            pst_pkg::MODE_IDENT:  extend = is_letter || is_digit;
            pst_pkg::MODE_NUMBER: extend = is_digit;
            pst_pkg::MODE_OPER:   extend = op_found;
            default:              extend = 1'b0;
        endcase
    end

    // token of the run in progress, reported when the run ends
    always_comb
    begin
        len_sat = rl_reg > RLW'(MAX_LEXEME - 1);
        len_ext = len_sat ? 32'(MAX_LEXEME - 1) : 32'(rl_reg);
        kw_hit  = ka_reg && kp_reg == 3'(pst_pkg::KEYWORD_LEN) &&
                  rl_reg == RLW'(pst_pkg::KEYWORD_LEN);
        unique case (mode_reg)
            pst_pkg::MODE_IDENT:
                pend_tok.kind = kw_hit ? pst_pkg::KIND_PROGRAM : pst_pkg::KIND_IDENT;
            pst_pkg::MODE_NUMBER:
                pend_tok.kind = pst_pkg::KIND_NUMBER;
            pst_pkg::MODE_OPER:
                pend_tok.kind = (rl_reg == RLW'(1)) ?
                                pst_pkg::KIND_PLUS + 5'(of_reg) : pst_pkg::KIND_ERROR;
            default:
                pend_tok.kind = pst_pkg::KIND_ERROR;
        endcase
        pend_tok.start = start_ext[15:0];
        pend_tok.len   = len_ext[4:0];
        pend_tok.trunc = len_sat;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        rl_next    = rl_reg;
        kp_next    = kp_reg;
        ka_next    = ka_reg;
        of_next    = of_reg;
        new_valid  = 1'b0;
        new_tok    = '0;
        new_tok.start = pos_ext[15:0];
        has_pending = !extend && mode_reg != pst_pkg::MODE_IDLE;

        if (extend)
        begin
            if (rl_reg < RLW'(MAX_LEXEME))
                rl_next = rl_reg + RLW'(1);
            if (mode_reg == pst_pkg::MODE_IDENT && ka_reg)
            begin
                if (kp_reg < 3'(pst_pkg::KEYWORD_LEN) &&
                    text_byte == pst_pkg::kw_char(kp_reg))
                    kp_next = kp_reg + 3'd1;
                else
                    ka_next = 1'b0;
            end
        end
        else
        begin
            mode_next = pst_pkg::MODE_IDLE;
            priority if (text_byte == pst_pkg::CHAR_NUL)
            begin
                new_valid    = 1'b1;
                new_tok.kind = pst_pkg::KIND_END;
            end
            else if (is_space)
            begin
            end
            else if (pu_found)
            begin
                new_valid    = 1'b1;
                new_tok.kind = pst_pkg::KIND_DOT + 5'(pu_code);
                new_tok.len  = 5'd1;
            end
            else if (op_found)
            begin
                mode_next  = pst_pkg::MODE_OPER;
                start_next = pos_reg;
                rl_next    = RLW'(1);
                of_next    = op_code;
            end
            else if (is_letter)
            begin
                mode_next  = pst_pkg::MODE_IDENT;
                start_next = pos_reg;
                rl_next    = RLW'(1);
                ka_next    = text_byte == pst_pkg::kw_char(3'd0);
                kp_next    = {2'b00, text_byte == pst_pkg::kw_char(3'd0)};
            end
            else if (is_digit)
            begin
                mode_next  = pst_pkg::MODE_NUMBER;
                start_next = pos_reg;
                rl_next    = RLW'(1);
            end
            else
            begin
                new_valid    = 1'b1;
                new_tok.kind = pst_pkg::KIND_ERROR;
                new_tok.len  = 5'd1;
            end
        end

        if (!extend && text_byte == pst_pkg::CHAR_NUL)
            pos_next = '0;
        else if (pos_reg != POS_MAX)
            pos_next = pos_reg + POSITION_BITS'(1);
        else
            pos_next = pos_reg;
    end

    assign tok_push      = accept && (has_pending || new_valid);
    assign tok_pair.two  = has_pending && new_valid;
    assign tok_pair.tok0 = has_pending ? pend_tok : new_tok;
    assign tok_pair.tok1 = new_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pst_pkg::MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            rl_reg    <= '0;
            kp_reg    <= '0;
            ka_reg    <= 1'b0;
            of_reg    <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            rl_reg    <= rl_next;
            kp_reg    <= kp_next;
            ka_reg    <= ka_next;
            of_reg    <= of_next;
        end
    end

`ifndef SYNTHESIS
    a_end_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_byte == pst_pkg::CHAR_NUL |=> pos_reg == '0 &&
        mode_reg == pst_pkg::MODE_IDLE)
        else $error("end of text did not clear position and mode");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != pst_pkg::MODE_IDLE |-> rl_reg != '0 &&
        rl_reg <= RLW'(MAX_LEXEME))
        else $error("run length out of range during a run");
`endif

endmodule
`default_nettype wire

// ===== src/pst_queue.sv =====
`default_nettype none
module pst_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  pst_pkg::pair_t      wr_data,
    output logic                q_full,
    input  wire logic           rd_en,
    output pst_pkg::pair_t      rd_data,
    output logic                q_valid
);

    localparam int DEPTH = pst_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pst_pkg::pair_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign q_full  = count_reg == CNT_W'(DEPTH);
    assign q_valid = count_reg != '0;
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("item pushed into full token queue");
`endif

endmodule
`default_nettype wire

// ===== src/pst_back.sv =====
`default_nettype none
module pst_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  pst_pkg::pair_t      q_data,
    output logic                q_rd,
    output logic                empty,
    input  wire logic           pop,
    output logic [4:0]          token_kind,
    output logic [15:0]         start_pos,
    output logic [4:0]          token_length,
    output logic                was_truncated,
    output logic                last_of_run
);

    pst_pkg::pair_t  pair_reg;
    logic            valid_reg;
    logic            phase_reg;
    logic            take, done;
    pst_pkg::token_t cur;

    assign take = pop && valid_reg;
    // pair finished once its final token is taken
    assign done = take && (phase_reg || !pair_reg.two);
    assign q_rd = !valid_reg || done;

    assign cur           = phase_reg ? pair_reg.tok1 : pair_reg.tok0;
    assign empty         = !valid_reg;
    assign token_kind    = cur.kind;
    assign start_pos     = cur.start;
    assign token_length  = cur.len;
    assign was_truncated = cur.trunc;
    assign last_of_run   = phase_reg || !pair_reg.two;

    always_ff @(posedge clk)
    begin
        if (q_rd && q_valid)
            pair_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            valid_reg <= q_valid;
            phase_reg <= 1'b0;
        end
        else if (take)
            phase_reg <= 1'b1;
    end

`ifndef SYNTHESIS
    a_phase_two: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> valid_reg && pair_reg.two)
        else $error("second token shown for a single-token item");
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take && !phase_reg && pair_reg.two |=> phase_reg && valid_reg)
        else $error("second token of a pair lost");
`endif

endmodule
`default_nettype wire

// ===== src/pascal_subset_tokenizer.sv =====
`default_nettype none
// Streaming tokenizer for a small Pascal subset. One text byte is taken per
// cycle whenever full is low; byte 0 ends the text and yields an end token.
// Each byte causes zero, one or two tokens, which leave one per cycle through
// empty/pop. A byte's tokens are written into the token queue at the edge that
// accepts it and then loaded into the registered output stage, where the first
// shows on the outputs and can be popped.
// Sustained input rate is one byte per cycle as long as tokens are popped at
// least as fast as they arise; the output port moves one token per cycle, so
// bytes that end a run and also emit a token of their own put two tokens
// through it. A four-entry token queue sits between the scanner and the output
// stage; full rises when it fills.
module pascal_subset_tokenizer #(
    parameter int MAX_LEXEME    = pst_pkg::MAX_LEXEME_DEF,
    parameter int POSITION_BITS = pst_pkg::POSITION_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [4:0]       token_kind,
    output logic [15:0]      start_pos,
    output logic [4:0]       token_length,
    output logic             was_truncated,
    output logic             last_of_run
);

    logic           accept;
    logic           tok_push;
    pst_pkg::pair_t tok_pair;
    logic           q_rd, q_valid;
    pst_pkg::pair_t q_data;

    assign accept = push && !full;

    pst_front #(
        .MAX_LEXEME    (MAX_LEXEME),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .tok_push  (tok_push),
        .tok_pair  (tok_pair)
    );

    pst_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_push),
        .wr_data (tok_pair),
        .q_full  (full),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .q_valid (q_valid)
    );

    pst_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_rd          (q_rd),
        .empty         (empty),
        .pop           (pop),
        .token_kind    (token_kind),
        .start_pos     (start_pos),
        .token_length  (token_length),
        .was_truncated (was_truncated),
        .last_of_run   (last_of_run)
    );

endmodule
`default_nettype wire

// ===== test/pascal_subset_tokenizer_check.sv =====
module pascal_subset_tokenizer_check
    import pst_pkg::*;
#(
    parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  text_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [4:0]  token_kind,
    input  logic [15:0] start_pos,
    input  logic [4:0]  token_length,
    input  logic        was_truncated,
    input  logic        last_of_run,
    output int          failures,
    output int          tokens_waiting,
    output int          tokens_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [55:0] OPER_SET  = "+-*/=<>";
    localparam logic [55:0] PUNCT_SET = ".;,:()";
    localparam logic [55:0] KW_TEXT   = "program";
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [4:0]  len;
        logic        trunc;
        logic        last;
    } lexeme_t;

    lexeme_t pending_tokens[$];
    int      mismatch_count = 0;
    int      checked_count = 0;

    // scanner state as predicted
    mode_t                    mode = MODE_IDLE;
    logic [15:0]              run_start = '0;
    int                       run_len = 0;
    int                       kw_hits = 0;
    bit                       kw_live = 1'b0;
    logic [2:0]               op_code = '0;
    logic [POSITION_BITS-1:0] pos = '0;

    // index of b within a packed character set of n chars, or -1
    function automatic int find_char(input logic [55:0] set, input int n, input logic [7:0] b);
        for (int i = 0; i < n; i++)
            if (set[8*(n-1-i) +: 8] == b)
                return i;
        return -1;
    endfunction

    function automatic logic [7:0] keyword_char(input int k);
        return KW_TEXT[8*(KEYWORD_LEN-1-k) +: 8];
    endfunction

    function automatic lexeme_t make_token(input logic [4:0] kind, input logic [15:0] start,
                                           input logic [4:0] len);
        lexeme_t t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.trunc = 1'b0;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic lexeme_t close_run();
        lexeme_t t;
        t = make_token(KIND_IDENT, run_start, 5'(run_len));
        if (run_len > MAX_LEXEME - 1) begin
            t.len   = 5'(MAX_LEXEME - 1);
            t.trunc = 1'b1;
        end
        case (mode)
            MODE_IDENT:
                if (kw_live && kw_hits == KEYWORD_LEN && run_len == KEYWORD_LEN)
                    t.kind = KIND_PROGRAM;
            MODE_NUMBER:
                t.kind = KIND_NUMBER;
            default:
                t.kind = (run_len == 1) ? 5'(KIND_PLUS + op_code) : KIND_ERROR;
        endcase
        return t;
    endfunction

    task automatic open_run(input mode_t m);
        mode      = m;
        run_start = 16'(pos);
        run_len   = 1;
    endtask

    // advance the predicted scanner by one text byte and queue its tokens
    task automatic scan_byte(input logic [7:0] b);
        lexeme_t made[$];
        int      op_idx;
        int      pu_idx;
        bit      ltr;
        bit      dig;
        bit      grows;
        bit      text_done;
        op_idx    = find_char(OPER_SET, 7, b);
        pu_idx    = find_char(PUNCT_SET, 6, b);
        ltr       = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == CHAR_UNDERSCORE;
        dig       = b >= "0" && b <= "9";
        text_done = 1'b0;
        grows = (mode == MODE_IDENT && (ltr || dig)) || (mode == MODE_NUMBER && dig) ||
                (mode == MODE_OPER && op_idx >= 0);
        if (grows) begin
            if (run_len < MAX_LEXEME)
                run_len++;
            if (mode == MODE_IDENT && kw_live) begin
                if (kw_hits < KEYWORD_LEN && b == keyword_char(kw_hits))
                    kw_hits++;
                else
                    kw_live = 1'b0;
            end
        end
        else begin
            if (mode != MODE_IDLE) begin
                made.push_back(close_run());
                mode = MODE_IDLE;
            end
            if (b == CHAR_NUL) begin
                made.push_back(make_token(KIND_END, 16'(pos), 5'd0));
                pos       = '0;
                text_done = 1'b1;
            end
            else if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
                // whitespace: nothing to report
            end
            else if (pu_idx >= 0) begin
                made.push_back(make_token(5'(KIND_DOT + pu_idx), 16'(pos), 5'd1));
            end
            else if (op_idx >= 0) begin
                open_run(MODE_OPER);
                op_code = 3'(op_idx);
            end
            else if (ltr) begin
                open_run(MODE_IDENT);
                kw_live = (b == keyword_char(0));
                kw_hits = kw_live;
            end
            else if (dig) begin
                open_run(MODE_NUMBER);
            end
            else begin
                made.push_back(make_token(KIND_ERROR, 16'(pos), 5'd1));
            end
        end
        if (!text_done && pos < POS_MAX)
            pos++;
        if (made.size() > 0)
            made[made.size()-1].last = 1'b1;
        foreach (made[i])
            pending_tokens.push_back(made[i]);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        lexeme_t want;
        if (!rst_n) begin
            mode      = MODE_IDLE;
            run_start = '0;
            run_len   = 0;
            kw_hits   = 0;
            kw_live   = 1'b0;
            op_code   = '0;
            pos       = '0;
            pending_tokens.delete();
        end
        else begin
            // compare first so an item accepted at this edge cannot match a result
            if (pop && !empty) begin
                if (pending_tokens.size() == 0) begin
                    $error("token with none expected: kind %0d start %0d len %0d",
                           token_kind, start_pos, token_length);
                    mismatch_count++;
                end
                else begin
                    want = pending_tokens.pop_front();
                    compare_field("token_kind", want.kind, token_kind);
                    compare_field("start_pos", want.start, start_pos);
                    compare_field("token_length", want.len, token_length);
                    compare_field("was_truncated", want.trunc, was_truncated);
                    compare_field("last_of_run", want.last, last_of_run);
                    checked_count++;
                end
            end
            if (push && !full)
                scan_byte(text_byte);
        end
        failures       <= mismatch_count;
        tokens_waiting <= pending_tokens.size();
        tokens_checked <= checked_count;
    end

endmodule

// ===== test/pascal_subset_tokenizer_test.sv =====
module pascal_subset_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    localparam int RANDOM_BYTES = 1500;
    localparam int PHASE_BYTES  = 375;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 10;
    localparam int LONG_TEXT    = 400;

    localparam logic [55:0] OPER_SET  = "+-*/=<>";
    localparam logic [55:0] PUNCT_SET = ".;,:()";
    localparam logic [55:0] KW_TEXT   = "program";

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  text_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [4:0]  token_length;
    logic        was_truncated;
    logic        last_of_run;
    int          failures;
    int          tokens_waiting;
    int          tokens_checked;

    int send_gap_max = 4;
    int pop_gap_max  = 4;
    int bytes_sent   = 0;

    pascal_subset_tokenizer dut (.*);

    pascal_subset_tokenizer_check u_check (.*);

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #10ms;
        $display("pascal_subset_tokenizer: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return "a" + 8'(r);
        else if (r < 52)
            return "A" + 8'(r - 26);
        return CHAR_UNDERSCORE;
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 62);
        if (r < 53)
            return rand_alpha();
        return "0" + 8'(r - 53);
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 5);
        // tab, newline, vertical tab, form feed, carriage return, or space
        return (r == 5) ? " " : 8'(9 + r);
    endfunction

    function automatic logic [7:0] rand_oper();
        return OPER_SET[8*$urandom_range(0, 6) +: 8];
    endfunction

    function automatic logic [7:0] rand_punct();
        return PUNCT_SET[8*$urandom_range(0, 5) +: 8];
    endfunction

    task automatic send_ident(input int n);
        send_byte(rand_alpha());
        for (int i = 1; i < n; i++)
            send_byte(rand_alnum());
    endtask

    // one lexeme-shaped chunk of text, mostly well formed
    task automatic send_word();
        int  pick;
        int  n;
        int  k;
        bit  stretch;
        pick    = $urandom_range(0, 99);
        stretch = ($urandom_range(0, 19) == 0);
        if (pick < 25) begin
            send_ident(stretch ? $urandom_range(29, 40) : $urandom_range(1, 8));
        end
        else if (pick < 32) begin
            // the keyword and near misses
            k = $urandom_range(0, 4);
            n = (k == 3) ? $urandom_range(1, 6) : KEYWORD_LEN;
            for (int i = 0; i < n; i++)
                send_byte((k == 4 && i == 3) ? rand_alnum() : KW_TEXT[8*(6-i) +: 8]);
            if (k == 2)
                send_byte(rand_alnum());
        end
        else if (pick < 45) begin
            n = stretch ? $urandom_range(30, 40) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte("0" + 8'($urandom_range(0, 9)));
        end
        else if (pick < 55) begin
            send_byte(rand_oper());
        end
        else if (pick < 60) begin
            n = stretch ? $urandom_range(33, 36) : $urandom_range(2, 4);
            for (int i = 0; i < n; i++)
                send_byte(rand_oper());
        end
        else if (pick < 75) begin
            send_byte(rand_punct());
        end
        else if (pick < 83) begin
            send_byte(8'($urandom_range(1, 255)));
        end
        else if (pick < 87) begin
            send_byte(CHAR_NUL);
        end
        else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                send_byte(rand_space());
        end
        if ($urandom_range(0, 9) < 7)
            send_byte(rand_space());
    endtask

    // text with an overlong run of each kind, separated by blanks and parens
    function automatic logic [7:0] long_text_char(input int i);
        if (i >= 100 && i < 140)
            return "a" + 8'(i % 26);
        if (i >= 200 && i < 241)
            return "0" + 8'(i % 10);
        if (i >= 300 && i < 336)
            return "=";
        if (i > 0 && i % 50 == 0)
            return "(";
        return " ";
    endfunction

    initial begin : token_sink
        int gap;
        int popped;
        popped = 0;
        wait (rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, pop_gap_max);
            // long hold-off so the sender backs up against full
            if (popped == 150 || popped == 700)
                gap = LONG_HOLD;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            popped++;
        end
    end

    initial begin : byte_source
        string intro;
        int    base;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        intro = "program(_Z9,42)+-;*/=<.>:";
        for (int i = 0; i < intro.len(); i++)
            send_byte(intro[i]);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h09);
        send_byte(CHAR_NUL);

        base = bytes_sent;
        while (bytes_sent - base < RANDOM_BYTES) begin
            case (((bytes_sent - base) / PHASE_BYTES) % 4)
                0: begin send_gap_max = 4; pop_gap_max = 4; end
                1: begin send_gap_max = 0; pop_gap_max = 4; end
                2: begin send_gap_max = 4; pop_gap_max = 0; end
                default: begin send_gap_max = 0; pop_gap_max = 0; end
            endcase
            send_word();
        end
        send_byte(CHAR_NUL);

        send_gap_max = 0;
        pop_gap_max  = 4;
        for (int i = 0; i < LONG_TEXT; i++)
            send_byte(long_text_char(i));
        send_byte(CHAR_NUL);
        send_byte("k");
        send_byte(CHAR_NUL);
        push <= 1'b0;

        @(posedge clk);
        while (tokens_waiting != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered: directed text, %0d random bytes over idle mixes, overlong runs",
                 RANDOM_BYTES);
        $display("%0d bytes in, %0d tokens checked", bytes_sent, tokens_checked);
        if (failures == 0)
            $display("pascal_subset_tokenizer: match");
        else
            $display("pascal_subset_tokenizer: mismatch");
        $finish;
    end

endmodule
